// ----- rtl/core/bank_address_key_table_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the key table datapath (bakt_dpath).
// ----------------------------------------------------------------------------
`ifndef BANK_ADDRESS_KEY_TABLE_DEFINES_SVH
`define BANK_ADDRESS_KEY_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BAKT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bank_address_key_table: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BAKT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bank_address_key_table: assertion failed");

`endif

// ----- rtl/core/bakt_pkg.sv -----
// ----------------------------------------------------------------------------
// bakt_pkg
// Types and constants shared by the bank/address key table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bakt_pkg;

   localparam int ENTRIES_DEFAULT = 32;
   localparam int FUNC_W          = 2;
   localparam int KEY_W           = 8;
   localparam int SLOT_W          = 5;

   localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic last_issue;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/core/bank_address_key_table.sv -----
// ----------------------------------------------------------------------------
// bank_address_key_table
// Small table of (bank, address) keys with find, insert and remove.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_func, req_bank, req_address
//   rsp      out        rsp_valid/rsp_stall   rsp_found, rsp_slot, rsp_table_full
//
// A request reads every slot of the key store through its single read port,
// one slot a cycle, and the result is registered at commit. A new request is
// taken only once the last has committed; req_stall is low only in idle.
// Reset clears all valid marks at once; no clearing pass is needed.
// A stalled result holds the commit of the next request, not its scan.
// ----------------------------------------------------------------------------
`default_nettype none

module bank_address_key_table #(
   parameter int ENTRIES = bakt_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [bakt_pkg::FUNC_W-1:0]   req_func,
   input  wire logic [bakt_pkg::KEY_W-1:0]    req_bank,
   input  wire logic [bakt_pkg::KEY_W-1:0]    req_address,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_found,
   output logic [bakt_pkg::SLOT_W-1:0]        rsp_slot,
   output logic                               rsp_table_full
);

   bakt_pkg::cmd_type    cmd;
   bakt_pkg::status_type status;

   bakt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bakt_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_func       (req_func),
      .req_bank       (req_bank),
      .req_address    (req_address),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_slot       (rsp_slot),
      .rsp_table_full (rsp_table_full)
   );

endmodule

`default_nettype wire

// ----- rtl/core/bakt_ctrl.sv -----
// ----------------------------------------------------------------------------
// bakt_ctrl
// Sequencer for one request: load, scan every slot, drain, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module bakt_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire bakt_pkg::status_type status,
   output bakt_pkg::cmd_type        cmd
);

   bakt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bakt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      case (state_ff)
         bakt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
            if (req_valid) begin
               state_in = bakt_pkg::ST_SCAN;
            end
         end
         bakt_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.last_issue) begin
               state_in = bakt_pkg::ST_DRAIN;
            end
         end
         bakt_pkg::ST_DRAIN: begin
            // The last slot's read data is compared in this cycle.
            state_in = bakt_pkg::ST_COMMIT;
         end
         bakt_pkg::ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = bakt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bakt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/bakt_dpath.sv -----
// ----------------------------------------------------------------------------
// bakt_dpath
// Key store, valid marks, slot scan with match and free-slot tracking, and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bank_address_key_table_defines.svh"

module bakt_dpath #(
   parameter int ENTRIES = bakt_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bakt_pkg::cmd_type                 cmd,
   output bakt_pkg::status_type                   status,
   input  wire logic [bakt_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [bakt_pkg::KEY_W-1:0]        req_bank,
   input  wire logic [bakt_pkg::KEY_W-1:0]        req_address,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_found,
   output logic [bakt_pkg::SLOT_W-1:0]            rsp_slot,
   output logic                                   rsp_table_full
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // Key store; a slot's contents only count while its valid mark is set.
   logic [bakt_pkg::KEY_W-1:0] mem_bank [ENTRIES];
   logic [bakt_pkg::KEY_W-1:0] mem_addr [ENTRIES];
   logic [ENTRIES-1:0]         valid_ff;

   logic [bakt_pkg::FUNC_W-1:0] func_ff;
   logic [bakt_pkg::KEY_W-1:0]  key_bank_ff;
   logic [bakt_pkg::KEY_W-1:0]  key_addr_ff;

   logic [IDX_W-1:0]           rd_idx_ff;
   logic [IDX_W-1:0]           cmp_idx_ff;
   logic                       cmp_pend_ff;
   logic [bakt_pkg::KEY_W-1:0] rd_bank_ff;
   logic [bakt_pkg::KEY_W-1:0] rd_addr_ff;

   logic             hit_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic             free_ff;
   logic [IDX_W-1:0] free_idx_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_found_ff;
   logic [bakt_pkg::SLOT_W-1:0] rsp_slot_ff;
   logic                        rsp_full_ff;

   logic             hit_now;
   logic             free_now;
   logic             ins_new;
   logic             ins_write;
   logic             rem_clear;
   logic [IDX_W-1:0] slot_idx;
   logic [IDX_W+bakt_pkg::SLOT_W-1:0] slot_ext;

   assign hit_now  = cmp_pend_ff && valid_ff[cmp_idx_ff]
                     && (rd_bank_ff == key_bank_ff) && (rd_addr_ff == key_addr_ff);
   assign free_now = cmp_pend_ff && !valid_ff[cmp_idx_ff];

   assign ins_new   = (func_ff == bakt_pkg::FUNC_INSERT) && !hit_ff;
   assign ins_write = ins_new && free_ff;
   assign rem_clear = (func_ff == bakt_pkg::FUNC_REMOVE) && hit_ff;

   always_comb begin
      slot_idx = '0;
      if (hit_ff) begin
         slot_idx = hit_idx_ff;
      end else if (ins_write) begin
         slot_idx = free_idx_ff;
      end
   end

   // Zero-extend then keep the low slot bits, for any table depth.
   assign slot_ext = {{bakt_pkg::SLOT_W{1'b0}}, slot_idx};

   assign status.last_issue = (rd_idx_ff == LAST_IDX);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff     <= req_func;
         key_bank_ff <= req_bank;
         key_addr_ff <= req_address;
      end
   end

   // Scan address and compare pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff   <= '0;
         cmp_pend_ff <= 1'b0;
      end else begin
         cmp_pend_ff <= cmd.scan;
         if (cmd.load) begin
            rd_idx_ff <= '0;
         end else if (cmd.scan) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         cmp_idx_ff <= rd_idx_ff;
      end
   end

   // Memory: one read port for the scan, one write port at commit.
   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         rd_bank_ff <= mem_bank[rd_idx_ff];
         rd_addr_ff <= mem_addr[rd_idx_ff];
      end
      if (cmd.commit && ins_write) begin
         mem_bank[free_idx_ff] <= key_bank_ff;
         mem_addr[free_idx_ff] <= key_addr_ff;
      end
   end

   // The lowest matching slot and the lowest free slot are kept.
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmd.load) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         if (hit_now && !hit_ff) begin
            hit_ff <= 1'b1;
         end
         if (free_now && !free_ff) begin
            free_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hit_now && !hit_ff) begin
         hit_idx_ff <= cmp_idx_ff;
      end
      if (free_now && !free_ff) begin
         free_idx_ff <= cmp_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit) begin
         if (ins_write) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end else if (rem_clear) begin
            valid_ff[hit_idx_ff] <= 1'b0;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_found_ff <= hit_ff;
         rsp_slot_ff  <= slot_ext[bakt_pkg::SLOT_W-1:0];
         rsp_full_ff  <= ins_new && !free_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_table_full = rsp_full_ff;

   `BAKT_ASSERT_NOW(a_commit_into_free_output, clock, reset, cmd.commit,
      !rsp_valid_ff || !rsp_stall)
   `BAKT_ASSERT_NEXT(a_commit_shows_result, clock, reset, cmd.commit, rsp_valid_ff)
   `BAKT_ASSERT_NOW(a_full_never_with_hit, clock, reset, rsp_valid_ff,
      !(rsp_found_ff && rsp_full_ff))
   `BAKT_ASSERT_NOW(a_free_slot_still_free, clock, reset, cmp_pend_ff && free_ff,
      !valid_ff[free_idx_ff])
   `BAKT_ASSERT_NOW(a_hit_slot_valid, clock, reset, cmd.commit && hit_ff,
      valid_ff[hit_idx_ff])

endmodule

`default_nettype wire
